FILE: src/ras_pkg.sv
// shared types and constants for the row argsort block
package ras_pkg;

  localparam int KEY_W     = 32;
  localparam int IDX_W     = 6;
  localparam int DEPTH_DEF = 64;

  // input transaction
  typedef struct packed {
    logic signed [KEY_W-1:0] sort_key;
    logic                    batch_end;
  } ras_in_t;

  // result transaction
  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic [IDX_W-1:0]        source_index;
    logic                    run_end;
    logic                    overflowed;
  } ras_out_t;

  // one stored row: key and its arrival index
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        idx;
  } ras_entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;   // latch incoming key, hole at top of store
    logic drop;     // store full, mark the batch as overflowed
    logic rd_top;   // read highest stored entry
    logic shift;    // move read entry up one slot, read the next one down
    logic place;    // write new key into the hole
    logic emit;     // read next sorted entry for output
  } ras_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic greater;    // entry read is larger than new key
    logic pos_one;    // hole is at slot one
    logic emit_last;  // current emit read is the final one
    logic last;       // latched batch end
  } ras_sts_t;

endpackage

FILE: src/ras_ram.sv
// generic single write, single read ram with registered read data
module ras_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/ras_ctrl.sv
// sequencer for insertion, drop and sorted read-out
module ras_ctrl
  import ras_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     batch_end,
  input  ras_sts_t sts,
  output ras_cmd_t cmd,
  output logic     busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.fill_full) begin
            cmd.drop  = 1'b1;
            state_nxt = batch_end ? S_EMIT : S_IDLE;
          end else if (sts.fill_zero) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.rd_top = 1'b1;
            state_nxt  = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (sts.greater) begin
          cmd.shift = 1'b1;
          state_nxt = sts.pos_one ? S_PLACE : S_SHIFT;
        end else begin
          cmd.place = 1'b1;
          state_nxt = sts.last ? S_EMIT : S_IDLE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: src/ras_dpath.sv
// key store, insertion shifting and result register
module ras_dpath
  import ras_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ras_in_t  in_data,
  input  ras_cmd_t cmd,
  output ras_sts_t sts,
  output logic     out_valid,
  output ras_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [KEY_W-1:0] key_r;
  logic                    last_r;
  logic [CW-1:0]           pos_r;
  logic [CW-1:0]           fill_r;
  logic                    drop_r;
  logic [CW-1:0]           emit_cnt_r;
  logic                    out_valid_r;
  logic                    run_end_r;
  logic                    ovf_r;

  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  ras_entry_t              wr_entry;
  ras_entry_t              rd_entry;
  logic                    emit_last;

  assign emit_last = (emit_cnt_r == (fill_r - CW'(1)));

  // ram address and data selection
  always_comb begin
    rd_en = cmd.rd_top | cmd.shift | cmd.emit;
    if (cmd.emit) begin
      rd_addr = AW'(emit_cnt_r);
    end else if (cmd.shift) begin
      rd_addr = AW'(pos_r - CW'(2));
    end else begin
      rd_addr = AW'(fill_r - CW'(1));
    end
    wr_en   = cmd.place | cmd.shift;
    wr_addr = AW'(pos_r);
    if (cmd.place) begin
      wr_entry.key = key_r;
      wr_entry.idx = IDX_W'(fill_r);
    end else begin
      wr_entry = rd_entry;
    end
  end

  ras_ram #(
    .WIDTH ($bits(ras_entry_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // incoming key and hole position
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= in_data.sort_key;
      pos_r <= fill_r;
    end else if (cmd.shift) begin
      pos_r <= pos_r - CW'(1);
    end
  end

  // batch bookkeeping and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= 1'b0;
      fill_r      <= '0;
      drop_r      <= 1'b0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      run_end_r   <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.accept) begin
        last_r <= in_data.batch_end;
      end
      if (cmd.drop) begin
        drop_r <= 1'b1;
      end
      if (cmd.place) begin
        fill_r <= fill_r + CW'(1);
      end
      if (cmd.emit) begin
        run_end_r <= emit_last;
        ovf_r     <= drop_r;
        if (emit_last) begin
          emit_cnt_r <= '0;
          fill_r     <= '0;
          drop_r     <= 1'b0;
        end else begin
          emit_cnt_r <= emit_cnt_r + CW'(1);
        end
      end
    end
  end

  // status to controller
  always_comb begin
    sts.fill_zero = (fill_r == '0);
    sts.fill_full = (fill_r == CW'(DEPTH));
    sts.greater   = ($signed(rd_entry.key) > $signed(key_r));
    sts.pos_one   = (pos_r == CW'(1));
    sts.emit_last = emit_last;
    sts.last      = last_r;
  end

  // result transaction
  assign out_valid             = out_valid_r;
  assign out_data.sorted_key   = rd_entry.key;
  assign out_data.source_index = rd_entry.idx;
  assign out_data.run_end      = run_end_r;
  assign out_data.overflowed   = ovf_r;

endmodule

FILE: src/row_argsort_by_key.sv
// top level of the stable argsort of a batch of fixed-point keys
//
//   channel  ports                    transfer
//   input    start, busy, in_data     start high and busy low at a clock edge
//   result   out_valid, out_data      out_valid high for one cycle, always taken
//
// Each stored key larger than an inserted key moves up one slot per cycle through
// the store ram's single read port and single write port. A key arriving at a
// full store is dropped. A batch-end transaction is followed by one result per
// stored key, one per cycle, starting once it is inserted or dropped; busy falls
// with the last read. Reset (rst_n low, synchronous) empties the store; the ram
// needs no clearing pass. Results cannot be stalled.
module row_argsort_by_key
  import ras_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ras_in_t  in_data,
  output logic     out_valid,
  output ras_out_t out_data
);

  ras_cmd_t cmd;
  ras_sts_t sts;

  ras_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .batch_end (in_data.batch_end),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  ras_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a sorted run leaves without gaps
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_end |=> out_valid)
    else $error("gap inside a sorted run");

  // nothing follows the end of a run
  a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_end |=> !out_valid)
    else $error("result after end of run");

  // results only come out of a read-out phase
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without read-out");

endmodule
